[sv/nearest_centroid_cluster_pass_defines.svh]
// Assertion macros shared by the nearest centroid cluster pass RTL
`ifndef NEAREST_CENTROID_CLUSTER_PASS_DEFINES_SVH
`define NEAREST_CENTROID_CLUSTER_PASS_DEFINES_SVH
// implication checked on every clock edge outside reset
`define NCC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define NCC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[sv/ncc_pkg.sv]
// Package with types and constants of the nearest centroid cluster pass
package ncc_pkg;
    localparam int NumClustersDef = 8;
    localparam int MaxPixelsDef   = 1048576;
    localparam int CompFracDef    = 4;
    localparam int CompW  = 13;
    localparam int DistW  = 28;
    localparam int TotW   = 48;
    localparam int SumW   = 33;
    localparam int AccW   = 34;
    localparam int CntW   = 21;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_END   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_SUM   = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIST,
        ST_ACC,
        ST_SUMMARY
    } state_t;

    // one classified item in the queue
    typedef struct packed {
        req_t               req;
        logic [2:0]         idx;
        logic signed [12:0] l;
        logic signed [12:0] u;
        logic signed [12:0] v;
        logic               vis;
    } item_t;
endpackage

[sv/ncc_front.sv]
// Front end: accepts items, drops unused codes and queues them
module ncc_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ncc_pkg::item_t in_item,
    output logic          q_valid,
    input  logic          q_take,
    output ncc_pkg::item_t q_item
);
    import ncc_pkg::*;
    localparam int Depth = 2;

    item_t     mem_reg [Depth];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push, pop;

    assign in_stall = (cnt_reg == 2'(Depth));
    assign push     = in_valid && !in_stall && (in_item.req != REQ_NONE);
    assign pop      = q_take && q_valid;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

`include "nearest_centroid_cluster_pass_defines.svh"
    `NCC_ASSERT_IMP(a_no_overflow, clk, rst_n, cnt_reg == 2'(Depth), !push || pop)
    `NCC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= 2'(Depth))
    `NCC_ASSERT_NEXT(a_push_visible, clk, rst_n, push, q_valid)
endmodule

[sv/ncc_back.sv]
// Back end: centroid loads, distance search, accumulation and pass summaries
module ncc_back
#(
    parameter int NUM_CLUSTERS = ncc_pkg::NumClustersDef,
    parameter int MAX_PIXELS   = ncc_pkg::MaxPixelsDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          active_clusters,
    input  logic                q_valid,
    output logic                q_take,
    input  ncc_pkg::item_t      q_item,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          result_kind,
    output logic [2:0]          cluster_index,
    output logic                counted,
    output logic [27:0]         min_distance,
    output logic [20:0]         weight,
    output logic signed [32:0]  sum_l,
    output logic signed [32:0]  sum_u,
    output logic signed [32:0]  sum_v,
    output logic [47:0]         total_distortion,
    output logic [20:0]         visible_pixels,
    output logic                last
);
    import ncc_pkg::*;
    localparam int Slots = (NUM_CLUSTERS < 8) ? NUM_CLUSTERS : 8;
    localparam int IW    = (Slots > 1) ? $clog2(Slots) : 1;
    localparam logic [TotW-1:0] DistMax = '1;

    state_t state_reg, state_next;
    item_t  cur_reg;
    logic signed [CompW-1:0] cl_reg [Slots];
    logic signed [CompW-1:0] cu_reg [Slots];
    logic signed [CompW-1:0] cv_reg [Slots];
    logic [CntW-1:0]         cnt_reg [Slots];
    logic signed [AccW-1:0]  sl_reg [Slots];
    logic signed [AccW-1:0]  su_reg [Slots];
    logic signed [AccW-1:0]  sv_reg [Slots];
    logic [TotW-1:0] dist_reg;
    logic [CntW-1:0] vis_reg;
    logic [DistW-1:0] d_reg [Slots];
    logic [IW-1:0]   k_reg;
    logic [3:0]      n_act;
    logic            obuf_full_reg;
    logic            out_free;

    logic [DistW-1:0] best_d;
    logic [IW-1:0]    best_k;
    logic             can_count;
    logic [TotW:0]    dsum;

    assign out_free  = !obuf_full_reg || !out_stall;
    assign out_valid = obuf_full_reg;

    always_comb
    begin
        n_act = active_clusters;
        if (n_act == 4'd0)
            n_act = 4'd1;
        if (n_act > 4'(Slots))
            n_act = 4'(Slots);
    end

    // compare registered distances, lowest index kept on ties
    always_comb
    begin
        best_d = d_reg[0];
        best_k = '0;
        for (int k = 1; k < Slots; k++)
        begin
            if ((4'(k) < n_act) && (d_reg[k] < best_d))
            begin
                best_d = d_reg[k];
                best_k = IW'(k);
            end
        end
        can_count = cur_reg.vis && (32'(vis_reg) < 32'(MAX_PIXELS));
        dsum      = {1'b0, dist_reg} + (TotW+1)'(best_d);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid && out_free)
                begin
                    case (q_item.req)
                        REQ_PIXEL: state_next = ST_DIST;
                        REQ_END:   state_next = ST_SUMMARY;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            ST_DIST:    state_next = ST_ACC;
            ST_ACC:     if (out_free) state_next = ST_IDLE;
            ST_SUMMARY:
                if (out_free && (4'(k_reg) + 4'd1 == n_act))
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take = (state_reg == ST_IDLE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            obuf_full_reg <= 1'b0;
            k_reg         <= '0;
            dist_reg      <= '0;
            vis_reg       <= '0;
            for (int k = 0; k < Slots; k++)
            begin
                cl_reg[k]  <= '0;
                cu_reg[k]  <= '0;
                cv_reg[k]  <= '0;
                cnt_reg[k] <= '0;
                sl_reg[k]  <= '0;
                su_reg[k]  <= '0;
                sv_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
                obuf_full_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    k_reg <= '0;
                    if (q_valid && out_free && q_item.req == REQ_LOAD)
                    begin
                        obuf_full_reg <= 1'b1;
                        if (32'(q_item.idx) < Slots)
                        begin
                            cl_reg[IW'(q_item.idx)] <= q_item.l;
                            cu_reg[IW'(q_item.idx)] <= q_item.u;
                            cv_reg[IW'(q_item.idx)] <= q_item.v;
                        end
                    end
                end
                ST_ACC:
                    if (out_free)
                    begin
                        obuf_full_reg <= 1'b1;
                        if (can_count)
                        begin
                            cnt_reg[best_k] <= cnt_reg[best_k] + 1'b1;
                            sl_reg[best_k]  <= sl_reg[best_k] + AccW'(cur_reg.l);
                            su_reg[best_k]  <= su_reg[best_k] + AccW'(cur_reg.u);
                            sv_reg[best_k]  <= sv_reg[best_k] + AccW'(cur_reg.v);
                            dist_reg <= dsum[TotW] ? DistMax : dsum[TotW-1:0];
                            vis_reg  <= vis_reg + 1'b1;
                        end
                    end
                ST_SUMMARY:
                    if (out_free)
                    begin
                        obuf_full_reg <= 1'b1;
                        k_reg <= k_reg + 1'b1;
                        if (4'(k_reg) + 4'd1 == n_act)
                        begin
                            dist_reg <= '0;
                            vis_reg  <= '0;
                            for (int k = 0; k < Slots; k++)
                            begin
                                cnt_reg[k] <= '0;
                                sl_reg[k]  <= '0;
                                su_reg[k]  <= '0;
                                sv_reg[k]  <= '0;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

    // payload: item capture, distances and output register
    always_ff @(posedge clk)
    begin
        if (q_take && q_valid)
            cur_reg <= q_item;
        if (state_reg == ST_DIST)
        begin
            for (int k = 0; k < Slots; k++)
            begin
                d_reg[k] <= DistW'(
                    (27'(cur_reg.l - cl_reg[k]) * 27'(cur_reg.l - cl_reg[k])) +
                    (27'(cur_reg.u - cu_reg[k]) * 27'(cur_reg.u - cu_reg[k])) +
                    (27'(cur_reg.v - cv_reg[k]) * 27'(cur_reg.v - cv_reg[k])));
            end
        end
        if (out_free)
        begin
            result_kind      <= KIND_ACK;
            cluster_index    <= q_item.idx;
            counted          <= 1'b0;
            min_distance     <= '0;
            weight           <= '0;
            sum_l            <= '0;
            sum_u            <= '0;
            sum_v            <= '0;
            total_distortion <= '0;
            visible_pixels   <= '0;
            last             <= 1'b1;
            if (state_reg == ST_ACC)
            begin
                result_kind   <= KIND_PIXEL;
                cluster_index <= cur_reg.vis ? 3'(best_k) : 3'd0;
                counted       <= can_count;
                min_distance  <= cur_reg.vis ? best_d : '0;
            end
            else if (state_reg == ST_SUMMARY)
            begin
                result_kind      <= KIND_SUM;
                cluster_index    <= 3'(k_reg);
                weight           <= cnt_reg[k_reg];
                sum_l            <= sl_reg[k_reg][SumW-1:0];
                sum_u            <= su_reg[k_reg][SumW-1:0];
                sum_v            <= sv_reg[k_reg][SumW-1:0];
                total_distortion <= dist_reg;
                visible_pixels   <= vis_reg;
                last             <= (4'(k_reg) + 4'd1 == n_act);
            end
        end
    end

`include "nearest_centroid_cluster_pass_defines.svh"
    `NCC_ASSERT_IMP(a_take_idle, clk, rst_n, q_take, state_reg == ST_IDLE)
    `NCC_ASSERT_IMP(a_stall_hold, clk, rst_n, obuf_full_reg && out_stall,
        state_next == state_reg || state_reg == ST_DIST)
    `NCC_ASSERT_NEXT(a_dist_acc, clk, rst_n, state_reg == ST_DIST, state_reg == ST_ACC)
endmodule

[sv/nearest_centroid_cluster_pass.sv]
// Top level of the nearest centroid cluster pass
// Usage:
//   Input channel in_valid/in_stall carries load, pixel and end-of-pass items;
//   result channel out_valid/out_stall carries one result per load or pixel
//   and one summary per active cluster on end of pass, last on the final one.
//   cfg_valid/cfg_ready writes active_clusters; write only while idle.
// Steps:
//   A load is handled as the back end takes it; a pixel passes capture,
//   distance registers for all centroids in parallel, then compare and
//   accumulate; an end of pass is taken, then gives one summary per active
//   cluster. A two-entry queue separates the front from the back end, so
//   items are taken while a result waits.
// Reset clears centroids, accumulators and active_clusters to 1.
// A stalled receiver holds the output register; the back end waits and the
// queue fills, after which in_stall rises.
module nearest_centroid_cluster_pass
#(
    parameter int NUM_CLUSTERS = ncc_pkg::NumClustersDef,
    parameter int MAX_PIXELS   = ncc_pkg::MaxPixelsDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [2:0]         centroid_index,
    input  logic signed [12:0] comp_l,
    input  logic signed [12:0] comp_u,
    input  logic signed [12:0] comp_v,
    input  logic               visible,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [2:0]         cluster_index,
    output logic               counted,
    output logic [27:0]        min_distance,
    output logic [20:0]        weight,
    output logic signed [32:0] sum_l,
    output logic signed [32:0] sum_u,
    output logic signed [32:0] sum_v,
    output logic [47:0]        total_distortion,
    output logic [20:0]        visible_pixels,
    output logic               last
);
    import ncc_pkg::*;

    logic [3:0] active_reg;
    item_t      in_item, q_item;
    logic       q_valid, q_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 4'd1;
        else if (cfg_valid)
            active_reg <= cfg_data;
    end

    always_comb
    begin
        in_item.req = req_t'(req_type);
        in_item.idx = centroid_index;
        in_item.l   = comp_l;
        in_item.u   = comp_u;
        in_item.v   = comp_v;
        in_item.vis = visible;
    end

    ncc_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    ncc_back #(.NUM_CLUSTERS(NUM_CLUSTERS), .MAX_PIXELS(MAX_PIXELS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .active_clusters(active_reg),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .cluster_index(cluster_index),
        .counted(counted), .min_distance(min_distance), .weight(weight),
        .sum_l(sum_l), .sum_u(sum_u), .sum_v(sum_v),
        .total_distortion(total_distortion), .visible_pixels(visible_pixels),
        .last(last)
    );
endmodule

[bench/nearest_centroid_cluster_pass_test.sv]
// Self-checking bench for the nearest centroid cluster pass
`timescale 1ns / 100ps

module nearest_centroid_cluster_pass_test;
    import ncc_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         idx;
        logic               cnt;
        logic [27:0]        mindist;
        logic [20:0]        wt;
        logic signed [32:0] sl;
        logic signed [32:0] su;
        logic signed [32:0] sv;
        logic [47:0]        tot;
        logic [20:0]        vis;
        logic               lst;
    } outcome_t;

    localparam longint DistSat = (64'd1 << 48) - 1;
    localparam int CycleLimit = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [3:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] req_type = 0;
    logic [2:0] centroid_index = 0;
    logic signed [12:0] comp_l = 0, comp_u = 0, comp_v = 0;
    logic visible = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] result_kind;
    logic [2:0] cluster_index;
    logic counted;
    logic [27:0] min_distance;
    logic [20:0] weight;
    logic signed [32:0] sum_l, sum_u, sum_v;
    logic [47:0] total_distortion;
    logic [20:0] visible_pixels;
    logic last;

    nearest_centroid_cluster_pass dut (.*);

    always #5 clk = ~clk;

    // predictor state
    longint cent [8][3];
    longint cl_count [8];
    longint cl_sum [8][3];
    longint distortion;
    longint counted_pixels;
    int     active_reg;

    item_t    pending_items[$];
    outcome_t expected_results[$];
    bit failed = 0;
    bit calm = 0;
    int cycles = 0;
    int tx_gap = 0, rx_gap = 0;

    function automatic int active_n();
        int a;
        a = active_reg;
        if (a == 0) a = 1;
        if (a > 8) a = 8;
        return a;
    endfunction

    task automatic clear_pass();
        for (int k = 0; k < 8; k++)
        begin
            cl_count[k] = 0;
            for (int j = 0; j < 3; j++) cl_sum[k][j] = 0;
        end
        distortion = 0;
        counted_pixels = 0;
    endtask

    task automatic predict_cluster(input item_t it);
        outcome_t o;
        longint c[3];
        longint d, bestd, t;
        int best, n;
        c[0] = it.l; c[1] = it.u; c[2] = it.v;
        o = '0;
        o.lst = 1;
        case (it.req)
            REQ_LOAD:
            begin
                for (int j = 0; j < 3; j++) cent[it.idx][j] = c[j];
                o.kind = KIND_ACK;
                o.idx = it.idx;
                expected_results.push_back(o);
            end
            REQ_PIXEL:
            begin
                o.kind = KIND_PIXEL;
                best = 0; bestd = 0;
                if (it.vis)
                begin
                    n = active_n();
                    for (int k = 0; k < n; k++)
                    begin
                        d = 0;
                        for (int j = 0; j < 3; j++)
                        begin
                            t = c[j] - cent[k][j];
                            d += t * t;
                        end
                        if (k == 0 || d < bestd)
                        begin
                            bestd = d; best = k;
                        end
                    end
                    if (counted_pixels < 1048576)
                    begin
                        o.cnt = 1;
                        cl_count[best]++;
                        for (int j = 0; j < 3; j++) cl_sum[best][j] += c[j];
                        distortion += bestd;
                        if (distortion > DistSat) distortion = DistSat;
                        counted_pixels++;
                    end
                end
                o.idx = best;
                o.mindist = bestd[27:0];
                expected_results.push_back(o);
            end
            REQ_END:
            begin
                n = active_n();
                for (int k = 0; k < n; k++)
                begin
                    o = '0;
                    o.kind = KIND_SUM;
                    o.idx = k;
                    o.wt = cl_count[k][20:0];
                    o.sl = cl_sum[k][0][32:0];
                    o.su = cl_sum[k][1][32:0];
                    o.sv = cl_sum[k][2][32:0];
                    o.tot = distortion[47:0];
                    o.vis = counted_pixels[20:0];
                    o.lst = (k + 1 == n);
                    expected_results.push_back(o);
                end
                clear_pass();
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [12:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return -13'sd4096;
            1: return 13'sd4095;
            2: return $urandom_range(0, 63) - 32;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t make_item(input req_t r, input int ix, input bit vis);
        item_t it;
        it.req = r; it.idx = ix;
        it.l = rand_comp(); it.u = rand_comp(); it.v = rand_comp();
        it.vis = vis;
        return it;
    endfunction

    // driver: pops one transaction when the previous one is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 0;
                end
                else if (pending_items.size() > 0 && !cfg_valid)
                begin
                    item_t it;
                    it = pending_items.pop_front();
                    predict_cluster(it);
                    in_valid <= 1;
                    req_type <= it.req;
                    centroid_index <= it.idx;
                    comp_l <= it.l; comp_u <= it.u; comp_v <= it.v;
                    visible <= it.vis;
                    if (!calm && $urandom_range(0, 9) == 0)
                        tx_gap <= $urandom_range(1, 11);
                end
                else
                    in_valid <= 0;
            end
            if (rx_gap > 0)
            begin
                out_stall <= 1;
                rx_gap <= rx_gap - 1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1;
                rx_gap <= $urandom_range(0, 10);
            end
            else
                out_stall <= 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            outcome_t got, want;
            got = '{result_kind, cluster_index, counted, min_distance, weight,
                    sum_l, sum_u, sum_v, total_distortion, visible_pixels, last};
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: %p", $time, got);
                failed = 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    failed = 1;
                end
            end
        end
        if (cycles > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_active(input int val);
        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (8) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        active_reg = val;
        @(posedge clk);
    endtask

    initial
    begin
        int settings[6] = '{8, 1, 0, 15, 3, 8};
        for (int k = 0; k < 8; k++)
            for (int j = 0; j < 3; j++) cent[k][j] = 0;
        clear_pass();
        active_reg = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, extremes, transparent, ignored code, ties
        pending_items.push_back(make_item(REQ_PIXEL, 0, 1));
        pending_items.push_back(make_item(REQ_END, 0, 0));
        write_active(8);
        for (int k = 0; k < 8; k++)
        begin
            item_t it;
            it = make_item(REQ_LOAD, k, 0);
            it.l = (k % 2) ? -13'sd4096 : 13'sd4095;
            it.u = (k < 4) ? 13'sd0 : -13'sd4096;
            it.v = 13'sd4095 - k;
            pending_items.push_back(it);
        end
        begin
            item_t it;
            it = make_item(REQ_LOAD, 5, 0);
            it.l = 13'sd4095; it.u = 13'sd0; it.v = 13'sd4095;
            pending_items.push_back(it);
            it = make_item(REQ_PIXEL, 0, 1);
            it.l = -13'sd4096; it.u = -13'sd4096; it.v = -13'sd4096;
            pending_items.push_back(it);
            it.l = 13'sd4095; it.u = 13'sd0; it.v = 13'sd4095;
            pending_items.push_back(it);
            it.vis = 0;
            pending_items.push_back(it);
            it.req = REQ_NONE;
            pending_items.push_back(it);
            pending_items.push_back(make_item(REQ_PIXEL, 7, 1));
            pending_items.push_back(make_item(REQ_END, 0, 0));
        end

        // random passes over several register settings
        for (int p = 0; p < 6; p++)
        begin
            write_active(settings[p]);
            if (p == 5) calm = 1;
            for (int i = 0; i < 36; i++)
            begin
                int r;
                r = $urandom_range(0, 19);
                if (r < 3)
                    pending_items.push_back(make_item(REQ_LOAD, $urandom_range(0, 7), 0));
                else if (r == 3)
                    pending_items.push_back(make_item(REQ_NONE, $urandom, $urandom));
                else if (r == 4)
                    pending_items.push_back(make_item(REQ_END, $urandom, $urandom));
                else
                    pending_items.push_back(make_item(REQ_PIXEL, $urandom,
                                                      $urandom_range(0, 5) != 0));
            end
            pending_items.push_back(make_item(REQ_END, 0, 0));
        end

        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/ncc_pkg.sv
sv/ncc_front.sv
sv/ncc_back.sv
sv/nearest_centroid_cluster_pass.sv
bench/nearest_centroid_cluster_pass_test.sv
